### hdl/hvps_pkg.sv
// Shared types, codes and helper functions of the high-voltage precharge sequencer.
package hvps_pkg;

    localparam int VOLT_W  = 10;
    localparam int TICK_W  = 16;
    localparam int MODE_W  = 3;
    localparam int CMD_W   = 2;
    localparam int RELAY_W = 3;
    localparam int APB_AW  = 4;
    localparam int APB_DW  = 32;
    localparam int REGIDX_W = 2;

    // Ratio test 20*mc > 19*batt, evaluated on a product wide enough for 20*1023
    localparam int PROD_W     = 15;
    localparam int RATIO_MC   = 20;
    localparam int RATIO_BATT = 19;

    localparam logic [VOLT_W-1:0] MIN_VOLT_RST     = VOLT_W'(400);
    localparam logic [VOLT_W-1:0] MAX_VOLT_RST     = VOLT_W'(600);
    localparam logic [TICK_W-1:0] TIMEOUT_TICK_RST = TICK_W'(50);
    localparam logic [TICK_W-1:0] BYPASS_TICK_RST  = TICK_W'(30);

    localparam logic [MODE_W-1:0] MODE_FAIL        = 3'd0;
    localparam logic [MODE_W-1:0] MODE_IDLE        = 3'd1;
    localparam logic [MODE_W-1:0] MODE_PRECHARGING = 3'd2;
    localparam logic [MODE_W-1:0] MODE_BYPASS      = 3'd3;
    localparam logic [MODE_W-1:0] MODE_PRECHARGED  = 3'd4;

    // Relay bits: bit0 AIR negative, bit1 precharge, bit2 AIR positive
    localparam logic [RELAY_W-1:0] RELAYS_SAFE     = 3'b000;
    localparam logic [RELAY_W-1:0] RELAYS_CHARGING = 3'b011;
    localparam logic [RELAY_W-1:0] RELAYS_ALL      = 3'b111;
    localparam logic [RELAY_W-1:0] RELAYS_RUN      = 3'b101;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK       = 2'd0,
        CMD_START      = 2'd1,
        CMD_BYPASS     = 2'd2,
        CMD_POWER_LOST = 2'd3
    } cmd_t;

    typedef enum logic [REGIDX_W-1:0] {
        REG_MIN_VOLT     = 2'd0,
        REG_MAX_VOLT     = 2'd1,
        REG_TIMEOUT_TICK = 2'd2,
        REG_BYPASS_TICK  = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [VOLT_W-1:0] min_voltage;
        logic [VOLT_W-1:0] max_voltage;
        logic [TICK_W-1:0] timeout_ticks;
        logic [TICK_W-1:0] bypass_ticks;
    } cfg_t;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [VOLT_W-1:0] battery_volts;
        logic [VOLT_W-1:0] motor_volts;
        logic              overtemp_ok;
    } item_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              neg_closed;
        logic              pre_closed;
        logic              pos_closed;
        logic              timed_out;
        logic              start_taken;
    } result_t;

    function automatic logic volts_ready(
        input logic [VOLT_W-1:0] batt,
        input logic [VOLT_W-1:0] mc,
        input logic [VOLT_W-1:0] vmin,
        input logic [VOLT_W-1:0] vmax
    );
        logic [PROD_W-1:0] mc_scaled;
        logic [PROD_W-1:0] batt_scaled;
        mc_scaled   = PROD_W'(mc) * PROD_W'(RATIO_MC);
        batt_scaled = PROD_W'(batt) * PROD_W'(RATIO_BATT);
        return (mc_scaled > batt_scaled) && (mc > vmin) && (batt > vmin)
            && (mc < vmax) && (batt < vmax);
    endfunction

    function automatic logic [TICK_W-1:0] sat_inc(input logic [TICK_W-1:0] c);
        return (c == {TICK_W{1'b1}}) ? c : c + TICK_W'(1);
    endfunction

endpackage

### hdl/hvps_in_if.sv
// Input item channel: valid/ready handshake with command and voltage readings.
interface hvps_in_if import hvps_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [VOLT_W-1:0] battery_volts;
    logic [VOLT_W-1:0] motor_volts;
    logic              overtemp_ok;

    modport source (
        output valid, command, battery_volts, motor_volts, overtemp_ok,
        input  ready
    );
    modport sink (
        input  valid, command, battery_volts, motor_volts, overtemp_ok,
        output ready
    );
endinterface

### hdl/hvps_out_if.sv
// Result channel: valid/ready handshake with mode and contactor commands.
interface hvps_out_if import hvps_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic              neg_closed;
    logic              pre_closed;
    logic              pos_closed;
    logic              timed_out;
    logic              start_taken;

    modport source (
        output valid, mode, neg_closed, pre_closed, pos_closed, timed_out, start_taken,
        input  ready
    );
    modport sink (
        input  valid, mode, neg_closed, pre_closed, pos_closed, timed_out, start_taken,
        output ready
    );
endinterface

### hdl/hvps_cfg_regs.sv
// APB configuration registers: voltage limits, timeout and bypass tick counts.
module hvps_cfg_regs import hvps_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t     cfg_reg;
    logic     wr_en;
    reg_idx_t idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[APB_AW-1:2]);
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_voltage   <= MIN_VOLT_RST;
            cfg_reg.max_voltage   <= MAX_VOLT_RST;
            cfg_reg.timeout_ticks <= TIMEOUT_TICK_RST;
            cfg_reg.bypass_ticks  <= BYPASS_TICK_RST;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_MIN_VOLT:     cfg_reg.min_voltage   <= pwdata[VOLT_W-1:0];
                REG_MAX_VOLT:     cfg_reg.max_voltage   <= pwdata[VOLT_W-1:0];
                REG_TIMEOUT_TICK: cfg_reg.timeout_ticks <= pwdata[TICK_W-1:0];
                REG_BYPASS_TICK:  cfg_reg.bypass_ticks  <= pwdata[TICK_W-1:0];
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_MIN_VOLT:     prdata = APB_DW'(cfg_reg.min_voltage);
            REG_MAX_VOLT:     prdata = APB_DW'(cfg_reg.max_voltage);
            REG_TIMEOUT_TICK: prdata = APB_DW'(cfg_reg.timeout_ticks);
            REG_BYPASS_TICK:  prdata = APB_DW'(cfg_reg.bypass_ticks);
            default:          prdata = '0;
        endcase
    end

endmodule

### hdl/hvps_seq_core.sv
// Sequencer state registers and the next-state rule for one item.
module hvps_seq_core import hvps_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    adv,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t res
);

    typedef enum logic [4:0] {
        ST_FAIL   = 5'b00001,
        ST_IDLE   = 5'b00010,
        ST_PRECHG = 5'b00100,
        ST_BYPASS = 5'b01000,
        ST_DONE   = 5'b10000
    } state_t;

    state_t             state_reg,  state_next;
    logic [RELAY_W-1:0] relay_reg,  relay_next;
    logic               armed_reg,  armed_next;
    logic [TICK_W-1:0]  tcount_reg, tcount_next;
    logic [TICK_W-1:0]  bcount_reg, bcount_next;
    logic               v_ok;
    logic               timed;
    logic               taken;
    logic [MODE_W-1:0]  mode_code;

    assign v_ok = volts_ready(item.battery_volts, item.motor_volts,
                              cfg.min_voltage, cfg.max_voltage);

    always_comb
    begin
        state_next  = state_reg;
        relay_next  = relay_reg;
        armed_next  = armed_reg;
        tcount_next = tcount_reg;
        bcount_next = bcount_reg;
        timed       = 1'b0;
        taken       = 1'b0;
        case (cmd_t'(item.command))
            CMD_TICK:
            begin
                case (state_reg)
                    ST_IDLE: relay_next = RELAYS_SAFE;
                    ST_PRECHG:
                    begin
                        relay_next = v_ok ? RELAYS_ALL : RELAYS_CHARGING;
                        if (v_ok)
                        begin
                            state_next = ST_DONE;
                        end
                    end
                    ST_BYPASS:
                    begin
                        relay_next  = RELAYS_CHARGING;
                        bcount_next = sat_inc(bcount_reg);
                        if (bcount_next >= cfg.bypass_ticks)
                        begin
                            state_next = ST_DONE;
                        end
                    end
                    ST_DONE: relay_next = RELAYS_RUN;
                    default:
                    begin
                        relay_next = RELAYS_SAFE;
                        state_next = item.overtemp_ok ? ST_IDLE : ST_FAIL;
                    end
                endcase
                // Timeout runs after the state rule, in every state
                if (armed_reg)
                begin
                    tcount_next = sat_inc(tcount_reg);
                    if (tcount_next >= cfg.timeout_ticks)
                    begin
                        armed_next = 1'b0;
                        if (v_ok)
                        begin
                            relay_next = RELAYS_ALL;
                        end
                        else
                        begin
                            state_next = ST_FAIL;
                            timed      = 1'b1;
                        end
                    end
                end
            end
            CMD_START:
            begin
                if (state_reg == ST_IDLE && item.battery_volts > cfg.min_voltage
                    && item.battery_volts < cfg.max_voltage)
                begin
                    relay_next  = RELAYS_CHARGING;
                    state_next  = ST_PRECHG;
                    armed_next  = 1'b1;
                    tcount_next = '0;
                    taken       = 1'b1;
                end
            end
            CMD_BYPASS:
            begin
                state_next  = ST_BYPASS;
                bcount_next = '0;
            end
            default: state_next = ST_FAIL;
        endcase
    end

    always_comb
    begin
        case (state_next)
            ST_IDLE:   mode_code = MODE_IDLE;
            ST_PRECHG: mode_code = MODE_PRECHARGING;
            ST_BYPASS: mode_code = MODE_BYPASS;
            ST_DONE:   mode_code = MODE_PRECHARGED;
            default:   mode_code = MODE_FAIL;
        endcase
    end

    assign res.mode        = mode_code;
    assign res.neg_closed  = relay_next[0];
    assign res.pre_closed  = relay_next[1];
    assign res.pos_closed  = relay_next[2];
    assign res.timed_out   = timed;
    assign res.start_taken = taken;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_FAIL;
            relay_reg  <= RELAYS_SAFE;
            armed_reg  <= 1'b0;
            tcount_reg <= '0;
            bcount_reg <= '0;
        end
        else if (adv)
        begin
            state_reg  <= state_next;
            relay_reg  <= relay_next;
            armed_reg  <= armed_next;
            tcount_reg <= tcount_next;
            bcount_reg <= bcount_next;
        end
    end

endmodule

### hdl/hv_precharge_sequencer.sv
// An accepted item waits in the input register, then moves on to the result register.
// Throughput: one item per cycle while results drain; the input register takes a new item
// whenever the result register is empty or draining, and can hold one while a result waits.
// The sequencer state advances only as an item moves from input register to result register.
// Reset (rst_n low, asynchronous): fail state, all relays open, timeout disarmed,
// counters zero, both channel stages empty, registers at their documented defaults.
module hv_precharge_sequencer import hvps_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    hvps_in_if.sink           in_ch,
    hvps_out_if.source        out_ch
);

    cfg_t    cfg;
    item_t   item_reg;
    logic    item_valid_reg, item_valid_next;
    result_t res_reg;
    result_t res_comb;
    logic    res_valid_reg,  res_valid_next;
    logic    in_xfer;
    logic    adv;

    hvps_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Move the held item into the result register when that slot is free or draining
    assign adv          = item_valid_reg && (!res_valid_reg || out_ch.ready);
    assign in_ch.ready  = !item_valid_reg || adv;
    assign in_xfer      = in_ch.valid && in_ch.ready;

    hvps_seq_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (adv),
        .item  (item_reg),
        .cfg   (cfg),
        .res   (res_comb)
    );

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (in_xfer)
        begin
            item_valid_next = 1'b1;
        end
        else if (adv)
        begin
            item_valid_next = 1'b0;
        end

        res_valid_next = res_valid_reg;
        if (adv)
        begin
            res_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    // Payload registers: capture on transfer, hold otherwise
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            item_reg.command       <= in_ch.command;
            item_reg.battery_volts <= in_ch.battery_volts;
            item_reg.motor_volts   <= in_ch.motor_volts;
            item_reg.overtemp_ok   <= in_ch.overtemp_ok;
        end
        if (adv)
        begin
            res_reg <= res_comb;
        end
    end

    assign out_ch.valid       = res_valid_reg;
    assign out_ch.mode        = res_reg.mode;
    assign out_ch.neg_closed  = res_reg.neg_closed;
    assign out_ch.pre_closed  = res_reg.pre_closed;
    assign out_ch.pos_closed  = res_reg.pos_closed;
    assign out_ch.timed_out   = res_reg.timed_out;
    assign out_ch.start_taken = res_reg.start_taken;

    // An item leaving the input stage always lands in the result register
    a_adv_fills: assert property (@(posedge clk) disable iff (!rst_n)
        adv |=> res_valid_reg)
        else $error("advanced item did not reach result register");

    // A held item that cannot advance must not be dropped
    a_item_held: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid_reg && !adv |=> item_valid_reg)
        else $error("stalled input item lost");

    // AIR positive never closes without AIR negative
    a_pos_needs_neg: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_reg.pos_closed |-> res_reg.neg_closed)
        else $error("positive contactor closed with negative open");

    // A timeout always leaves the sequencer in fail
    a_timeout_fail: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_reg.timed_out |-> res_reg.mode == MODE_FAIL)
        else $error("timeout reported outside fail mode");

    // An accepted start enters precharging with the precharge relay closed
    a_start_prechg: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_reg.start_taken
            |-> res_reg.mode == MODE_PRECHARGING && res_reg.pre_closed)
        else $error("accepted start did not enter precharging");

endmodule
